// ===== src/psg_pkg.sv =====
package psg_pkg;

  localparam int NOISE_PHASES_DEF = 32768;
  localparam int TONE_PHASES      = 32;

  localparam int PERIOD_W = 18;
  localparam int LEVEL_W  = 4;
  localparam int TONE_PW  = 5;
  localparam int NOISE_PW = 15;

  localparam logic [PERIOD_W-1:0] TONE_STEP  = 18'd8192;
  localparam logic [PERIOD_W-1:0] NOISE_STEP = 18'd512;

  localparam logic [1:0] CH_NOISE = 2'd0;
  localparam logic [1:0] CH_TONE1 = 2'd1;

  localparam logic [1:0] RATE_TONE1 = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;
  localparam logic [3:0]         NCTRL_RESET = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_ITER,
    S_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_TICK,
    K_SET,
    K_PEEK
  } kind_t;

  typedef enum logic [2:0] {
    G_TONE3_FREQ,
    G_TONE3_LEVEL,
    G_TONE2_FREQ,
    G_TONE2_LEVEL,
    G_TONE1_FREQ,
    G_TONE1_LEVEL,
    G_NOISE_CTRL,
    G_NOISE_LEVEL
  } grp_t;

  function automatic logic [PERIOD_W-1:0] noise_period(input logic [1:0] rate,
                                                       input logic white);
    logic [PERIOD_W-1:0] p;
    case (rate)
      2'd0: begin
        p = 18'h00400;
      end
      2'd1: begin
        p = 18'h00800;
      end
      default: begin
        p = 18'h01000;
      end
    endcase
    if (white) begin
      p = p << 1;
    end
    return p;
  endfunction

endpackage

// ===== src/psg_register_and_phase_counters.sv =====
// Four-channel sound generator: register interface and phase counters.
// Channel 0 is noise, channels 1 to 3 are tones.
// Input channel (in_valid/in_ready, op, data): op 0 writes one register
// byte, op 1 runs one output sample tick. Output channel (out_valid/
// out_ready) returns one snapshot of phases, levels and noise mode per item.
// Per-channel period, counter and phase live in a 4-entry memory that is
// read, modified and written back one channel at a time.
// An item that touches no channel record (level or tone-nibble latch, zero
// frequency byte) goes straight to the result; a frequency or noise-control
// write makes one memory pass, a rate 3 noise write also reads tone 1's
// period, and a tone 1 write at rate 3 also updates noise. A tick passes over
// all four channels, each in a reload loop that adds its period once per cycle
// until the counter is no longer negative (up to 3 * 128 + 8 reloads in all).
// Items are worked on one at a time; the next item is taken while a result
// still waits for out_ready, and its result waits until that one is gone.
// Reset sets the state, register file and valid flags; memory entries read
// as reset values (period 0xFFC0, counter, phase zero) until written back.
module psg_register_and_phase_counters
  import psg_pkg::*;
#(
  parameter int NOISE_PHASES = NOISE_PHASES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [7:0]          data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NOISE_PW-1:0] noise_phase,
  output logic [TONE_PW-1:0]  tone1_phase,
  output logic [TONE_PW-1:0]  tone2_phase,
  output logic [TONE_PW-1:0]  tone3_phase,
  output logic [LEVEL_W-1:0]  noise_level,
  output logic [LEVEL_W-1:0]  tone1_level,
  output logic [LEVEL_W-1:0]  tone2_level,
  output logic [LEVEL_W-1:0]  tone3_level,
  output logic [3:0]          noise_mode
);

  localparam int PHW = $clog2(NOISE_PHASES);
  localparam logic [PHW-1:0] NOISE_WRAP = PHW'(NOISE_PHASES - 1);
  localparam logic [PHW-1:0] TONE_WRAP  = PHW'(TONE_PHASES - 1);

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] cnt;
    logic [PHW-1:0]      phase;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{period: 18'h0FFC0, cnt: '0, phase: '0};

  state_t state, state_next;

  // register file
  logic [3:0]         freq_low [4];
  logic [LEVEL_W-1:0] level [4];
  logic [3:0]         noise_ctrl;
  logic [1:0]         target;
  logic [7:0]         last_latch;

  // phase shadows for the snapshot
  logic [PHW-1:0]     nphase;
  logic [TONE_PW-1:0] tphase [1:3];

  // channel memory
  chan_rec_t mem [4];
  logic [3:0] mem_vld;
  chan_rec_t  rd_q;
  logic       rd_vld;
  chan_rec_t  rd_rec;
  logic       mem_we;

  // item plan
  logic                is_tick;
  logic [1:0]          step;
  logic [1:0]          plan_last;
  logic [1:0]          plan_ch0, plan_ch1;
  kind_t               plan_kind0, plan_kind1;
  logic [PERIOD_W-1:0] plan_period;
  logic                plan_clr, plan_copy;
  logic [PERIOD_W-1:0] peek_period;

  // working copy of one channel
  logic [PERIOD_W-1:0] w_period;
  logic [PERIOD_W:0]   w_cnt;
  logic [PHW-1:0]      w_phase;

  logic [1:0]          cur_ch;
  kind_t               cur_kind;
  logic [PERIOD_W-1:0] cur_step;
  logic [PHW-1:0]      cur_wrap;

  logic in_xfer, out_free, out_load;

  // write decode
  grp_t                grp;
  logic                nw;
  logic [1:0]          nw_rate;
  logic [9:0]          freq;
  logic                go;
  logic [1:0]          d_last, d_ch0, d_ch1;
  kind_t               d_kind0, d_kind1;
  logic [PERIOD_W-1:0] d_period;
  logic                d_clr, d_copy;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    grp      = grp_t'(data[6:4]);
    nw       = data[7] ? (grp == G_NOISE_CTRL) : (grp_t'(last_latch[6:4]) == G_NOISE_CTRL);
    nw_rate  = data[1:0];
    freq     = {data[5:0], freq_low[target]};
    d_ch0    = CH_NOISE;
    d_ch1    = CH_NOISE;
    d_kind0  = K_SET;
    d_kind1  = K_SET;
    d_last   = 2'd0;
    d_period = '0;
    d_clr    = 1'b1;
    d_copy   = 1'b0;
    go       = 1'b0;
    if (op) begin
      go     = 1'b1;
      d_last = 2'd3;
    end else if (nw) begin
      go       = 1'b1;
      d_period = noise_period(nw_rate, data[2]);
      d_copy   = (nw_rate == RATE_TONE1);
      d_clr    = (nw_rate != RATE_TONE1) || (nw_rate != noise_ctrl[1:0]);
      if (nw_rate == RATE_TONE1) begin
        d_ch0   = CH_TONE1;
        d_kind0 = K_PEEK;
        d_last  = 2'd1;
      end
    end else if (!data[7] && freq != '0) begin
      go       = 1'b1;
      d_ch0    = target;
      d_period = {2'b00, freq, 6'b000000};
      if (noise_ctrl[1:0] == RATE_TONE1 && target == CH_TONE1) begin
        d_last = 2'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = go ? S_RD : S_DONE;
        end
      end
      S_RD: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        state_next = (cur_kind == K_TICK) ? S_ITER : S_WR;
      end
      S_ITER: begin
        if (!w_cnt[PERIOD_W]) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        state_next = (step == plan_last) ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    if (is_tick) begin
      cur_ch   = step + 2'd1;
      cur_kind = K_TICK;
    end else if (step == 2'd0) begin
      cur_ch   = plan_ch0;
      cur_kind = plan_kind0;
    end else begin
      cur_ch   = plan_ch1;
      cur_kind = plan_kind1;
    end
    cur_step = (cur_ch == CH_NOISE) ? NOISE_STEP : TONE_STEP;
    cur_wrap = (cur_ch == CH_NOISE) ? NOISE_WRAP : TONE_WRAP;
    rd_rec   = rd_vld ? rd_q : REC_RESET;
  end

  // channel memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_ch] <= '{period: w_period, cnt: w_cnt[PERIOD_W-1:0], phase: w_phase};
    end
    rd_q <= mem[cur_ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_vld[cur_ch] <= 1'b1;
      end
      rd_vld <= mem_vld[cur_ch];
    end
  end

  // register file updates on an accepted write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        freq_low[i] <= '0;
        level[i]    <= LEVEL_RESET;
      end
      noise_ctrl <= NCTRL_RESET;
      target     <= CH_NOISE;
      last_latch <= '0;
    end else if (in_xfer && !op) begin
      if (data[7]) begin
        last_latch <= data;
        case (grp)
          G_TONE3_FREQ: begin
            freq_low[3] <= data[3:0];
            target      <= 2'd3;
          end
          G_TONE3_LEVEL: begin
            level[3] <= 4'd15 - data[3:0];
          end
          G_TONE2_FREQ: begin
            freq_low[2] <= data[3:0];
            target      <= 2'd2;
          end
          G_TONE2_LEVEL: begin
            level[2] <= 4'd15 - data[3:0];
          end
          G_TONE1_FREQ: begin
            freq_low[1] <= data[3:0];
            target      <= 2'd1;
          end
          G_TONE1_LEVEL: begin
            level[1] <= 4'd15 - data[3:0];
          end
          G_NOISE_CTRL: begin
            noise_ctrl <= data[3:0];
          end
          default: begin
            level[0] <= 4'd15 - data[3:0];
          end
        endcase
      end else if (nw) begin
        noise_ctrl <= data[3:0];
      end
    end
  end

  // plan capture
  always_ff @(posedge clk) begin
    if (rst) begin
      is_tick <= 1'b0;
    end else if (in_xfer) begin
      is_tick <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      plan_last   <= d_last;
      plan_ch0    <= d_ch0;
      plan_ch1    <= d_ch1;
      plan_kind0  <= d_kind0;
      plan_kind1  <= d_kind1;
      plan_period <= d_period;
      plan_clr    <= d_clr;
      plan_copy   <= d_copy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (in_xfer) begin
      step <= '0;
    end else if (state == S_WR) begin
      step <= step + 2'd1;
    end
  end

  // read-modify-write datapath
  always_ff @(posedge clk) begin
    case (state)
      S_MOD: begin
        w_phase <= rd_rec.phase;
        case (cur_kind)
          K_TICK: begin
            w_period <= rd_rec.period;
            w_cnt    <= {1'b0, rd_rec.cnt} - {1'b0, cur_step};
          end
          K_PEEK: begin
            peek_period <= rd_rec.period;
            w_period    <= rd_rec.period;
            w_cnt       <= {1'b0, rd_rec.cnt};
          end
          default: begin
            w_period <= plan_copy ? peek_period : plan_period;
            w_cnt    <= plan_clr ? '0 : {1'b0, rd_rec.cnt};
          end
        endcase
      end
      S_ITER: begin
        if (w_cnt[PERIOD_W]) begin
          if (w_period == '0) begin
            w_cnt <= '0;
          end else begin
            w_cnt   <= w_cnt + {1'b0, w_period};
            w_phase <= (w_phase == cur_wrap) ? '0 : w_phase + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nphase <= '0;
      for (int i = 1; i < 4; i++) begin
        tphase[i] <= '0;
      end
    end else if (state == S_WR && cur_kind == K_TICK) begin
      if (cur_ch == CH_NOISE) begin
        nphase <= w_phase;
      end else begin
        tphase[cur_ch] <= w_phase[TONE_PW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      noise_phase <= NOISE_PW'(nphase);
      tone1_phase <= tphase[1];
      tone2_phase <= tphase[2];
      tone3_phase <= tphase[3];
      noise_level <= level[0];
      tone1_level <= level[1];
      tone2_level <= level[2];
      tone3_level <= level[3];
      noise_mode  <= noise_ctrl;
    end
  end

endmodule

// ===== src/psg_checker.sv =====
module psg_checker
  import psg_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [NOISE_PW-1:0] noise_phase,
  input logic [TONE_PW-1:0]  tone1_phase,
  input logic [LEVEL_W-1:0]  noise_level,
  input logic [3:0]          noise_mode
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // items taken whose result has not yet been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_phase) &&
      $stable(tone1_phase) && $stable(noise_level) && $stable(noise_mode))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result with no item outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3 && !(pending == 2'd2 && in_ready))
    else $error("too many items in flight");

endmodule

bind psg_register_and_phase_counters psg_checker u_psg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_phase (noise_phase),
  .tone1_phase (tone1_phase),
  .noise_level (noise_level),
  .noise_mode  (noise_mode)
);
